// ===== design/tedet_pkg.sv =====
// tedet_pkg: shared types and constants of the threshold event detector
`timescale 1ns / 1ps

package tedet_pkg;

   // fixed widths of levels, limits and reported indices
   localparam int LEVEL_BITS = 17;
   localparam int LIMIT_BITS = 32;
   localparam int OUT_BITS   = 32;
   localparam int CSR_ADDR_BITS = 3;

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_BITS-1:0] CSR_POLARITY  = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EDGE      = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UPPER     = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_LEN   = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX_LEN   = 3'd5;

   // polarity modes, any other code means magnitude
   localparam logic [1:0] MODE_ABOVE = 2'd0;
   localparam logic [1:0] MODE_BELOW = 2'd1;

   // configuration seen by the front and back parts
   typedef struct packed {
      logic [1:0]                   polarity_mode;
      logic signed [LEVEL_BITS-1:0] threshold_level;
      logic signed [LEVEL_BITS-1:0] edge_level;
      logic signed [LEVEL_BITS-1:0] upper_level;
      logic [LIMIT_BITS-1:0]        min_length;
      logic [LIMIT_BITS-1:0]        max_length;
   } cfg_type;

endpackage

// ===== design/tedet_front.sv =====
// tedet_front: key forming, run tracking and candidate event emission
`timescale 1ns / 1ps

module tedet_front import tedet_pkg::*; #(
   parameter int INDEX_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        accept,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                        last_in_series,
   output logic                        emit,
   output logic [3*INDEX_BITS:0]       emit_data
);

   localparam int KEY_BITS = ((SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS) + 1;

   // key of a value for the current polarity
   function automatic logic signed [KEY_BITS-1:0] key_of(
      input logic signed [KEY_BITS-1:0] v,
      input logic [1:0]                 mode
   );
      logic signed [KEY_BITS-1:0] r;
      unique case (mode)
         MODE_ABOVE: r = v;
         MODE_BELOW: r = -v;
         default:    r = v[KEY_BITS-1] ? -v : v;
      endcase
      return r;
   endfunction

   logic [INDEX_BITS-1:0]      sample_index_ff, sample_index_in;
   logic                       in_run_ff, in_run_in;
   logic                       reached_ff, reached_in;
   logic [INDEX_BITS-1:0]      start_ff, start_in;
   logic [INDEX_BITS-1:0]      peak_index_ff, peak_index_in;
   logic signed [KEY_BITS-1:0] peak_key_ff, peak_key_in;
   logic [INDEX_BITS-1:0]      last_index_ff, last_index_in;

   logic signed [KEY_BITS-1:0] sample_key, thr_key, edge_key, upper_key, emit_peak_key;
   logic                       reach, beyond;
   logic [INDEX_BITS-1:0]      emit_start, emit_peak, emit_stop;

   // keys of the sample and the levels
   always_comb begin
      sample_key = key_of({{(KEY_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample},
                          cfg.polarity_mode);
      thr_key    = key_of({{(KEY_BITS-LEVEL_BITS){cfg.threshold_level[LEVEL_BITS-1]}},
                           cfg.threshold_level}, cfg.polarity_mode);
      edge_key   = key_of({{(KEY_BITS-LEVEL_BITS){cfg.edge_level[LEVEL_BITS-1]}},
                           cfg.edge_level}, cfg.polarity_mode);
      upper_key  = key_of({{(KEY_BITS-LEVEL_BITS){cfg.upper_level[LEVEL_BITS-1]}},
                           cfg.upper_level}, cfg.polarity_mode);
      reach      = sample_key >= thr_key;
      beyond     = (sample_key >= edge_key) || reach;
   end

   // run tracking and event emission on each accepted item
   always_comb begin
      sample_index_in = sample_index_ff;
      in_run_in       = in_run_ff;
      reached_in      = reached_ff;
      start_in        = start_ff;
      peak_index_in   = peak_index_ff;
      peak_key_in     = peak_key_ff;
      last_index_in   = last_index_ff;
      emit            = 1'b0;
      emit_start      = start_ff;
      emit_peak       = peak_index_ff;
      emit_stop       = last_index_ff;
      emit_peak_key   = peak_key_ff;
      if (accept) begin
         if (beyond) begin
            if (!in_run_ff) begin
               start_in      = sample_index_ff;
               peak_index_in = sample_index_ff;
               peak_key_in   = sample_key;
               reached_in    = reach;
            end else begin
               if (sample_key > peak_key_ff) begin
                  peak_index_in = sample_index_ff;
                  peak_key_in   = sample_key;
               end
               reached_in = reached_ff | reach;
            end
            last_index_in = sample_index_ff;
            in_run_in     = 1'b1;
            if (last_in_series) begin
               emit          = reached_in;
               emit_start    = start_in;
               emit_peak     = peak_index_in;
               emit_stop     = sample_index_ff;
               emit_peak_key = peak_key_in;
               in_run_in     = 1'b0;
               reached_in    = 1'b0;
            end
         end else if (in_run_ff) begin
            emit       = reached_ff;
            in_run_in  = 1'b0;
            reached_in = 1'b0;
         end
         // index counter, saturating, back to zero after the series
         if (last_in_series) begin
            sample_index_in = '0;
            in_run_in       = 1'b0;
            reached_in      = 1'b0;
         end else if (!(&sample_index_ff)) begin
            sample_index_in = sample_index_ff + 1'b1;
         end
      end
      emit_data = {emit_start, emit_peak, emit_stop, (emit_peak_key <= upper_key)};
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         in_run_ff       <= 1'b0;
         reached_ff      <= 1'b0;
      end else begin
         sample_index_ff <= sample_index_in;
         in_run_ff       <= in_run_in;
         reached_ff      <= reached_in;
      end
   end

   // run payload
   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      peak_index_ff <= peak_index_in;
      peak_key_ff   <= peak_key_in;
      last_index_ff <= last_index_in;
   end

endmodule

// ===== design/tedet_fifo.sv =====
// tedet_fifo: short queue of candidate events between front and back
`timescale 1ns / 1ps

module tedet_fifo #(
   parameter int WIDTH = 97
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_push, do_pop;

   // pointer and fill count
   always_comb begin
      full      = count_ff == (PTR_BITS+1)'(DEPTH);
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
      head_data = store_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/tedet_back.sv =====
// tedet_back: length and peak checks, result output register
`timescale 1ns / 1ps

module tedet_back import tedet_pkg::*; #(
   parameter int INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic [3*INDEX_BITS:0] head_data,
   input  logic                  head_empty,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [OUT_BITS-1:0]   rsp_event_start,
   output logic [OUT_BITS-1:0]   rsp_event_peak,
   output logic [OUT_BITS-1:0]   rsp_event_stop
);

   localparam int LEN_BITS = (INDEX_BITS > LIMIT_BITS) ? INDEX_BITS : LIMIT_BITS;

   logic [INDEX_BITS-1:0] ev_start, ev_peak, ev_stop;
   logic                  peak_ok, ok_min, ok_max, pass;
   logic [LEN_BITS-1:0]   length;
   logic                  valid_ff, valid_in;
   logic [OUT_BITS-1:0]   start_ff, start_in, peak_ff, peak_in, stop_ff, stop_in;

   // event checks
   always_comb begin
      {ev_start, ev_peak, ev_stop, peak_ok} = head_data;
      length = LEN_BITS'(ev_stop) - LEN_BITS'(ev_start);
      ok_min = (cfg.min_length == '0) || (length >= LEN_BITS'(cfg.min_length));
      ok_max = (cfg.max_length == '0) || (length <= LEN_BITS'(cfg.max_length));
      pass   = ok_min && ok_max && peak_ok;
   end

   // output register, refilled in the cycle it is taken
   always_comb begin
      head_pop = !head_empty && (!valid_ff || rsp_pop);
      valid_in = valid_ff && !rsp_pop;
      start_in = start_ff;
      peak_in  = peak_ff;
      stop_in  = stop_ff;
      if (head_pop) begin
         valid_in = pass;
         start_in = OUT_BITS'(ev_start);
         peak_in  = OUT_BITS'(ev_peak);
         stop_in  = OUT_BITS'(ev_stop);
      end
      rsp_empty       = !valid_ff;
      rsp_event_start = start_ff;
      rsp_event_peak  = peak_ff;
      rsp_event_stop  = stop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      peak_ff  <= peak_in;
      stop_ff  <= stop_in;
   end

endmodule

// ===== design/threshold_event_detector.sv =====
// threshold_event_detector: top level, configuration registers and part wiring
//
//   channel   direction  handshake              payload
//   req_      in         req_push / req_full    req_sample, req_last_in_series
//   rsp_      out        rsp_pop / rsp_empty    rsp_event_start, _peak, _stop
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One item is taken per cycle unless req_full is high; the front is combinational,
// so an event is written to the queue at the edge that takes the item closing its
// run, and appears on rsp_ once the back has loaded it into its output register.
// A four-entry queue between front and back lets each side stall on its own;
// req_full rises only when that queue is full.
// Synchronous reset clears the run state, the index counter, the queue and
// every configuration register to zero. csr_ready is always high.
`timescale 1ns / 1ps

module threshold_event_detector import tedet_pkg::*; #(
   parameter int INDEX_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                         req_last_in_series,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [OUT_BITS-1:0]          rsp_event_start,
   output logic [OUT_BITS-1:0]          rsp_event_peak,
   output logic [OUT_BITS-1:0]          rsp_event_stop,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_ADDR_BITS-1:0]     csr_index,
   input  logic [LIMIT_BITS-1:0]        csr_wdata
);

   localparam int REC_BITS = 3 * INDEX_BITS + 1;

   cfg_type               cfg_ff, cfg_in;
   logic                  accept, emit, q_full, q_empty, q_pop;
   logic [REC_BITS-1:0]   emit_data, head_data;

   // configuration registers
   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POLARITY:  cfg_in.polarity_mode   = csr_wdata[1:0];
            CSR_THRESHOLD: cfg_in.threshold_level = csr_wdata[LEVEL_BITS-1:0];
            CSR_EDGE:      cfg_in.edge_level      = csr_wdata[LEVEL_BITS-1:0];
            CSR_UPPER:     cfg_in.upper_level     = csr_wdata[LEVEL_BITS-1:0];
            CSR_MIN_LEN:   cfg_in.min_length      = csr_wdata;
            CSR_MAX_LEN:   cfg_in.max_length      = csr_wdata;
            default:       cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   tedet_front #(
      .INDEX_BITS  (INDEX_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .accept         (accept),
      .sample         (req_sample),
      .last_in_series (req_last_in_series),
      .emit           (emit),
      .emit_data      (emit_data)
   );

   tedet_fifo #(
      .WIDTH (REC_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (emit_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (head_data),
      .empty     (q_empty)
   );

   tedet_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_data       (head_data),
      .head_empty      (q_empty),
      .head_pop        (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_event_start (rsp_event_start),
      .rsp_event_peak  (rsp_event_peak),
      .rsp_event_stop  (rsp_event_stop)
   );

endmodule

// ===== tb/threshold_event_detector_tb.sv =====
// threshold_event_detector_tb: self-checking testbench of the threshold event detector
`timescale 1ns / 1ps

module threshold_event_detector_tb;
   import tedet_pkg::*;

   localparam int SAMPLE_BITS = 16;
   localparam int BATCH_ITEMS = 240;
   localparam int TARGET_ITEMS = 1700;
   localparam int SETTLE_CYCLES = 8;

   // one reported event
   typedef struct packed {
      logic [OUT_BITS-1:0] start_idx;
      logic [OUT_BITS-1:0] peak_idx;
      logic [OUT_BITS-1:0] stop_idx;
   } det_event_type;

   // event predictor and store of expected events
   class event_scoreboard;
      logic [1:0]                   mode;
      logic signed [LEVEL_BITS-1:0] thr_level;
      logic signed [LEVEL_BITS-1:0] edge_lvl;
      logic signed [LEVEL_BITS-1:0] upper_lvl;
      logic [LIMIT_BITS-1:0]        min_len;
      logic [LIMIT_BITS-1:0]        max_len;
      logic [31:0]                  next_idx;
      bit                           in_run;
      bit                           run_reached;
      logic [31:0]                  run_start;
      logic [31:0]                  run_peak;
      logic [31:0]                  run_last;
      int                           peak_key;
      det_event_type                expected_events[$];
      int                           fail_count;

      function new();
         mode = MODE_ABOVE;
         thr_level = '0;
         edge_lvl = '0;
         upper_lvl = '0;
         min_len = '0;
         max_len = '0;
         next_idx = '0;
         in_run = 1'b0;
         run_reached = 1'b0;
         run_start = '0;
         run_peak = '0;
         run_last = '0;
         peak_key = 0;
         fail_count = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_BITS-1:0] index, logic [LIMIT_BITS-1:0] data);
         case (index)
            CSR_POLARITY:  mode = data[1:0];
            CSR_THRESHOLD: thr_level = data[LEVEL_BITS-1:0];
            CSR_EDGE:      edge_lvl = data[LEVEL_BITS-1:0];
            CSR_UPPER:     upper_lvl = data[LEVEL_BITS-1:0];
            CSR_MIN_LEN:   min_len = data;
            CSR_MAX_LEN:   max_len = data;
            default:       ;
         endcase
      endfunction

      // compare key: plain, negated or magnitude
      function int key_of(int v);
         if (mode == MODE_ABOVE) return v;
         if (mode == MODE_BELOW) return -v;
         return (v < 0) ? -v : v;
      endfunction

      // end of a run: qualify it and note the event
      function void close_run();
         logic [31:0]   len;
         det_event_type ev;
         if (in_run && run_reached) begin
            len = run_last - run_start;
            if ((min_len == 0 || len >= min_len) && (max_len == 0 || len <= max_len) &&
                peak_key <= key_of(int'(upper_lvl))) begin
               ev.start_idx = run_start;
               ev.peak_idx = run_peak;
               ev.stop_idx = run_last;
               expected_events.push_back(ev);
            end
         end
         in_run = 1'b0;
         run_reached = 1'b0;
      endfunction

      function void note_item(logic signed [SAMPLE_BITS-1:0] sample, logic last);
         logic [31:0] cur;
         int          k;
         bit          reach;
         bit          beyond;
         cur = next_idx;
         k = key_of(int'(sample));
         reach = k >= key_of(int'(thr_level));
         beyond = (k >= key_of(int'(edge_lvl))) || reach;
         if (beyond) begin
            if (!in_run) begin
               in_run = 1'b1;
               run_reached = 1'b0;
               run_start = cur;
               run_peak = cur;
               peak_key = k;
            end else if (k > peak_key) begin
               run_peak = cur;
               peak_key = k;
            end
            if (reach) run_reached = 1'b1;
            run_last = cur;
            if (last) close_run();
         end else if (in_run) begin
            close_run();
         end
         // index restarts with each series and saturates otherwise
         if (last) begin
            next_idx = '0;
            in_run = 1'b0;
            run_reached = 1'b0;
         end else if (next_idx != '1) begin
            next_idx = next_idx + 1;
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
         end
      endfunction

      function void check_result(logic [31:0] start_v, logic [31:0] peak_v, logic [31:0] stop_v);
         det_event_type ev;
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event: expected none, actual start %0d peak %0d stop %0d",
                     $time, start_v, peak_v, stop_v);
            fail_count++;
         end else begin
            ev = expected_events.pop_front();
            compare_field("event_start", ev.start_idx, start_v);
            compare_field("event_peak", ev.peak_idx, peak_v);
            compare_field("event_stop", ev.stop_idx, stop_v);
         end
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_last_in_series = 1'b0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic [OUT_BITS-1:0]           rsp_event_start;
   logic [OUT_BITS-1:0]           rsp_event_peak;
   logic [OUT_BITS-1:0]           rsp_event_stop;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_ADDR_BITS-1:0]      csr_index = '0;
   logic [LIMIT_BITS-1:0]         csr_wdata = '0;

   event_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;

   threshold_event_detector #(
      .INDEX_BITS (32),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_sample        (req_sample),
      .req_last_in_series(req_last_in_series),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_start   (rsp_event_start),
      .rsp_event_peak    (rsp_event_peak),
      .rsp_event_stop    (rsp_event_stop),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run time limit
   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   // result side: random pop, check each accepted event
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         rsp_pop = ($urandom_range(0, 99) >= recv_idle_pct);
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            board.check_result(rsp_event_start, rsp_event_peak, rsp_event_stop);
         end
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // sample whose key under the given mode is close to the wanted key
   function automatic logic signed [SAMPLE_BITS-1:0] sample_for_key(int key, logic [1:0] mode);
      if (mode == MODE_ABOVE) return clamp_sample(key);
      if (mode == MODE_BELOW) return clamp_sample(-key);
      if (key < 0) key = 0;
      return $urandom_range(0, 1) ? clamp_sample(key) : clamp_sample(-key);
   endfunction

   // level register value for a wanted key, sign-extended to the write width
   function automatic logic [LIMIT_BITS-1:0] level_for_key(int key, logic [1:0] mode);
      int lvl;
      if (mode == MODE_ABOVE) lvl = key;
      else if (mode == MODE_BELOW) lvl = -key;
      else lvl = $urandom_range(0, 1) ? key : -key;
      if (lvl > 65535) lvl = 65535;
      if (lvl < -65536) lvl = -65536;
      return lvl;
   endfunction

   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] index,
                            input logic [LIMIT_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(input logic [1:0] mode, input logic [LIMIT_BITS-1:0] thr,
                            input logic [LIMIT_BITS-1:0] edg, input logic [LIMIT_BITS-1:0] upp,
                            input logic [LIMIT_BITS-1:0] min_v,
                            input logic [LIMIT_BITS-1:0] max_v);
      write_csr(CSR_POLARITY, {30'd0, mode});
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_EDGE, edg);
      write_csr(CSR_UPPER, upp);
      write_csr(CSR_MIN_LEN, min_v);
      write_csr(CSR_MAX_LEN, max_v);
   endtask

   // offer one item, with random sender gaps, until it is taken
   task automatic push_item(input logic signed [SAMPLE_BITS-1:0] sample, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_sample = sample;
      req_last_in_series = last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_item(sample, last);
      items_sent++;
      @(negedge clock);
   endtask

   // wait until every expected event has come, then let the pipeline settle
   task automatic drain();
      req_push = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random configuration, then series of quiet stretches and pulses
   task automatic run_random_batch(input int n_items);
      logic [1:0] mode;
      int e_key;
      int t_key;
      int u_key;
      int sent;
      int series_len;
      int quiet_left;
      int pulse_left;
      int key;
      logic [LIMIT_BITS-1:0] upp;
      logic signed [SAMPLE_BITS-1:0] sample;
      mode = 2'($urandom_range(0, 3));
      e_key = (mode == MODE_ABOVE || mode == MODE_BELOW) ?
              int'($urandom_range(0, 12000)) - 2000 : int'($urandom_range(0, 6000));
      if ($urandom_range(0, 99) < 85) t_key = e_key + $urandom_range(0, 6000);
      else t_key = e_key - int'($urandom_range(1, 3000));
      if ($urandom_range(0, 99) < 75) u_key = t_key + $urandom_range(2000, 20000);
      else u_key = t_key + $urandom_range(0, 3000);
      upp = ($urandom_range(0, 9) == 0) ? 32'h0000_FFFF : level_for_key(u_key, mode);
      write_all(mode, level_for_key(t_key, mode), level_for_key(e_key, mode), upp,
                ($urandom_range(0, 99) < 60) ? 32'd0 : $urandom_range(1, 5),
                ($urandom_range(0, 99) < 60) ? 32'd0 : $urandom_range(3, 20));
      sent = 0;
      while (sent < n_items) begin
         series_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(6, 40);
         quiet_left = $urandom_range(0, 3);
         pulse_left = (quiet_left == 0) ? $urandom_range(1, 10) : 0;
         for (int i = 0; i < series_len; i++) begin
            if (pulse_left > 0) begin
               if ($urandom_range(0, 99) < 35) key = t_key + $urandom_range(0, 8000);
               else if (t_key > e_key) key = e_key + $urandom_range(0, t_key - e_key - 1);
               else key = e_key + $urandom_range(0, 2000);
               pulse_left--;
               if (pulse_left == 0) quiet_left = $urandom_range(1, 5);
            end else begin
               key = e_key - int'($urandom_range(1, 4000));
               quiet_left--;
               if (quiet_left <= 0) pulse_left = $urandom_range(1, 10);
            end
            // some raw noise so that every sample bit toggles
            if ($urandom_range(0, 99) < 8) sample = SAMPLE_BITS'($urandom);
            else sample = sample_for_key(key, mode);
            push_item(sample, i == series_len - 1);
         end
         sent += series_len;
      end
      drain();
   endtask

   // stimulus
   initial begin
      int batch;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 35;
      recv_idle_pct = 46;

      // above mode: edge below threshold, repeated peak, closes by sample and by end
      write_all(MODE_ABOVE, 32'd100, 32'd50, 32'd32767, 32'd0, 32'd0);
      push_item(16'sd0, 1'b0);
      push_item(16'sd50, 1'b0);
      push_item(16'sd100, 1'b0);
      push_item(16'sh7FFF, 1'b0);
      push_item(16'sh7FFF, 1'b0);
      push_item(16'sd49, 1'b0);
      push_item(16'sh8000, 1'b0);
      push_item(16'sd60, 1'b0);
      push_item(16'sd70, 1'b0);
      push_item(16'sd0, 1'b0);
      push_item(16'sd200, 1'b1);
      push_item(16'sd150, 1'b0);
      push_item(16'sd40, 1'b1);
      push_item(16'sd120, 1'b0);
      push_item(16'sd130, 1'b1);
      drain();

      // below mode at the level extremes: all beyond edge, threshold out of reach
      write_all(MODE_BELOW, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_0000,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(16'sh7FFF, 1'b0);
      push_item(16'sh8000, 1'b1);
      drain();

      // unused mode code: threshold inside edge, peak and length limits
      write_all(2'd3, 32'd10, 32'd20000, 32'd100, 32'd1, 32'd1);
      push_item(-16'sd50, 1'b0);
      push_item(16'sd60, 1'b0);
      push_item(-16'sd5, 1'b0);
      push_item(16'sd200, 1'b0);
      push_item(16'sd3, 1'b0);
      push_item(16'sd50, 1'b0);
      push_item(-16'sd60, 1'b0);
      push_item(16'sd70, 1'b1);
      drain();

      // random batches under the three idling regimes
      batch = 0;
      while (items_sent < TARGET_ITEMS && batch < 40) begin
         if (items_sent < TARGET_ITEMS / 3) begin
            send_idle_pct = 35;
            recv_idle_pct = 46;
         end else if (items_sent < 2 * TARGET_ITEMS / 3) begin
            send_idle_pct = 46;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_random_batch(BATCH_ITEMS);
         batch++;
      end

      drain();
      if (board.fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
